FILE: rtl/core/sts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Types and constants shared by the token scanner modules.
// ----------------------------------------------------------------------------
package sts_pkg;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_COMMENT = 4'd1,
      MODE_OP      = 4'd2,
      MODE_STRING  = 4'd3,
      MODE_INT     = 4'd4,
      MODE_DOT     = 4'd5,
      MODE_FRAC    = 4'd6,
      MODE_EXP     = 4'd7,
      MODE_EXPD    = 4'd8,
      MODE_IDENT   = 4'd9
   } mode_type;

   localparam logic [5:0] KIND_EOF     = 6'd0;
   localparam logic [5:0] KIND_PLUS    = 6'd1;
   localparam logic [5:0] KIND_MINUS   = 6'd2;
   localparam logic [5:0] KIND_STAR    = 6'd3;
   localparam logic [5:0] KIND_POW     = 6'd4;
   localparam logic [5:0] KIND_SLASH   = 6'd5;
   localparam logic [5:0] KIND_GT      = 6'd6;
   localparam logic [5:0] KIND_GE      = 6'd7;
   localparam logic [5:0] KIND_LT      = 6'd8;
   localparam logic [5:0] KIND_LE      = 6'd9;
   localparam logic [5:0] KIND_ASSIGN  = 6'd10;
   localparam logic [5:0] KIND_EQ      = 6'd11;
   localparam logic [5:0] KIND_NE      = 6'd12;
   localparam logic [5:0] KIND_DOT     = 6'd13;
   localparam logic [5:0] KIND_COMMA   = 6'd14;
   localparam logic [5:0] KIND_SEMI    = 6'd15;
   localparam logic [5:0] KIND_LPAREN  = 6'd16;
   localparam logic [5:0] KIND_RPAREN  = 6'd17;
   localparam logic [5:0] KIND_LBRACE  = 6'd18;
   localparam logic [5:0] KIND_RBRACE  = 6'd19;
   localparam logic [5:0] KIND_STRING  = 6'd20;
   localparam logic [5:0] KIND_NUMBER  = 6'd21;
   localparam logic [5:0] KIND_IDENT   = 6'd22;
   localparam logic [5:0] KIND_KW0     = 6'd23;
   localparam logic [5:0] KIND_UNKNOWN = 6'd38;

   localparam int KW_COUNT = 15;
   localparam int KW_MAX   = 8;

   typedef logic [8*KW_MAX-1:0] kw_text_type;

   function automatic kw_text_type kw_text(input int idx);
      kw_text_type t;
      t = '0;
      unique case (idx)
         0:  t[23:0] = {"t", "e", "l"};
         1:  t[39:0] = {"n", "u", "f", "e", "d"};
         2:  t[15:0] = {"f", "i"};
         3:  t[31:0] = {"e", "s", "l", "e"};
         4:  t[39:0] = {"e", "l", "i", "h", "w"};
         5:  t[63:0] = {"e", "u", "n", "i", "t", "n", "o", "c"};
         6:  t[39:0] = {"k", "a", "e", "r", "b"};
         7:  t[47:0] = {"n", "r", "u", "t", "e", "r"};
         8:  t[39:0] = {"t", "n", "i", "r", "p"};
         9:  t[15:0] = {"r", "o"};
         10: t[23:0] = {"d", "n", "a"};
         11: t[23:0] = {"t", "o", "n"};
         12: t[31:0] = {"e", "u", "r", "t"};
         13: t[39:0] = {"e", "s", "l", "a", "f"};
         default: t[23:0] = {"l", "i", "n"};
      endcase
      return t;
   endfunction

   function automatic logic [3:0] kw_len(input int idx);
      logic [3:0] l;
      unique case (idx)
         2, 9:              l = 4'd2;
         0, 10, 11, 14:     l = 4'd3;
         3, 12:             l = 4'd4;
         7:                 l = 4'd6;
         5:                 l = 4'd8;
         default:           l = 4'd5;
      endcase
      return l;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_front
// Scanner state machine: classifies each byte and forms up to three tokens.
// ----------------------------------------------------------------------------
module sts_front #(
   parameter int OFFSET_WIDTH    = 24,
   parameter int LINE_WIDTH      = 20,
   parameter int KEYWORD_MAX_LEN = 8
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   input  wire  [7:0]                 char_byte,
   input  wire                        end_of_source,
   output logic [2:0]                 tok_count,
   output logic [3*6-1:0]             tok_kind,
   output logic [3*OFFSET_WIDTH-1:0]  tok_offset,
   output logic [3*OFFSET_WIDTH-1:0]  tok_length,
   output logic [3*LINE_WIDTH-1:0]    tok_line,
   output logic [3*OFFSET_WIDTH-1:0]  tok_column
);

   localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;
   localparam logic [LINE_WIDTH-1:0]   LN_MAX  = '1;
   localparam int WL_W = $clog2(KEYWORD_MAX_LEN + 2);
   localparam logic [WL_W-1:0] WL_OVER = WL_W'(KEYWORD_MAX_LEN + 1);

   sts_pkg::mode_type mode_ff, mode_in;
   logic [7:0] pend_ff, pend_in;
   logic [OFFSET_WIDTH-1:0] soff_ff, soff_in, len_ff, len_in, scol_ff, scol_in;
   logic [OFFSET_WIDTH-1:0] coff_ff, coff_in, ccol_ff, ccol_in;
   logic [LINE_WIDTH-1:0] sln_ff, sln_in, cln_ff, cln_in;
   logic [8*KEYWORD_MAX_LEN-1:0] wbuf_ff, wbuf_in;
   logic [WL_W-1:0] wlen_ff, wlen_in;

   logic [5:0] word_k;
   always_comb begin
      word_k = sts_pkg::KIND_IDENT;
      for (int i = sts_pkg::KW_COUNT - 1; i >= 0; i--) begin
         if (wlen_ff == WL_W'(sts_pkg::kw_len(i)) &&
             wbuf_ff[63:0] == sts_pkg::kw_text(i))
            word_k = sts_pkg::KIND_KW0 + 6'(i);
      end
   end

   always_comb begin
      logic [7:0] c;
      logic rescan, done;
      logic [5:0] k;
      c = char_byte;
      mode_in = mode_ff; pend_in = pend_ff;
      soff_in = soff_ff; len_in = len_ff; scol_in = scol_ff; sln_in = sln_ff;
      coff_in = coff_ff; ccol_in = ccol_ff; cln_in = cln_ff;
      wbuf_in = wbuf_ff; wlen_in = wlen_ff;
      tok_count = '0;
      tok_kind = '0; tok_offset = '0; tok_length = '0; tok_line = '0; tok_column = '0;
      rescan = 1'b0; done = 1'b0; k = '0;

      if (in_valid) begin
         if (end_of_source) begin
            unique case (mode_ff)
               sts_pkg::MODE_OP:   emit_k(op_single(pend_ff));
               sts_pkg::MODE_STRING: emit_k(sts_pkg::KIND_UNKNOWN);
               sts_pkg::MODE_INT, sts_pkg::MODE_FRAC, sts_pkg::MODE_EXP,
               sts_pkg::MODE_EXPD: emit_k(sts_pkg::KIND_NUMBER);
               sts_pkg::MODE_DOT: begin
                  emit_k(sts_pkg::KIND_NUMBER); begin_t(); take_c(1'b0); emit_k(sts_pkg::KIND_DOT);
               end
               sts_pkg::MODE_IDENT: emit_k(word_k);
               default: ;
            endcase
            begin_t(); emit_k(sts_pkg::KIND_EOF); clear_s();
         end else begin
            rescan = (mode_ff == sts_pkg::MODE_IDLE);
            unique case (mode_ff)
               sts_pkg::MODE_IDLE: ;
               sts_pkg::MODE_COMMENT: begin
                  take_c(c == "\n");
                  if (c == "\n") mode_in = sts_pkg::MODE_IDLE;
               end
               sts_pkg::MODE_OP: begin
                  mode_in = sts_pkg::MODE_IDLE;
                  if (c == ((pend_ff == "*") ? 8'("*") : 8'("="))) begin
                     take_c(1'b0); emit_k(op_double(pend_ff));
                  end else begin
                     emit_k(op_single(pend_ff)); rescan = 1'b1;
                  end
               end
               sts_pkg::MODE_STRING: begin
                  take_c(1'b0);
                  if (c == "\"") begin
                     emit_k(sts_pkg::KIND_STRING); mode_in = sts_pkg::MODE_IDLE;
                  end
               end
               sts_pkg::MODE_INT, sts_pkg::MODE_FRAC: begin
                  if (sts_pkg::is_digit(c)) take_c(1'b0);
                  else if (c == "." && mode_ff == sts_pkg::MODE_INT)
                     mode_in = sts_pkg::MODE_DOT;
                  else if (c == "e" || c == "E") begin
                     take_c(1'b0); mode_in = sts_pkg::MODE_EXP;
                  end else done = 1'b1;
               end
               sts_pkg::MODE_DOT: begin
                  if (sts_pkg::is_digit(c)) begin
                     take_c(1'b0); take_c(1'b0); mode_in = sts_pkg::MODE_FRAC;
                  end else begin
                     emit_k(sts_pkg::KIND_NUMBER); begin_t(); take_c(1'b0);
                     emit_k(sts_pkg::KIND_DOT);
                     mode_in = sts_pkg::MODE_IDLE; rescan = 1'b1;
                  end
               end
               sts_pkg::MODE_EXP: begin
                  if (sts_pkg::is_digit(c) || c == "+" || c == "-") begin
                     take_c(1'b0); mode_in = sts_pkg::MODE_EXPD;
                  end else done = 1'b1;
               end
               sts_pkg::MODE_EXPD: begin
                  if (sts_pkg::is_digit(c)) take_c(1'b0);
                  else done = 1'b1;
               end
               sts_pkg::MODE_IDENT: begin
                  if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c) || c == "-" || c == "_")
                  begin
                     take_c(1'b0); word_put(c);
                  end else begin
                     emit_k(word_k); mode_in = sts_pkg::MODE_IDLE; rescan = 1'b1;
                  end
               end
               default: begin
                  mode_in = sts_pkg::MODE_IDLE; rescan = 1'b1;
               end
            endcase
            if (done) begin
               emit_k(sts_pkg::KIND_NUMBER); mode_in = sts_pkg::MODE_IDLE; rescan = 1'b1;
            end
            if (rescan) begin
               k = sts_pkg::KIND_UNKNOWN;
               priority case (c)
                  8'h00: begin
                     begin_t(); take_c(1'b0); emit_k(sts_pkg::KIND_EOF); clear_s();
                  end
                  " ", "\t", "\r", "\n": take_c(1'b1);
                  "#": begin
                     take_c(1'b0); mode_in = sts_pkg::MODE_COMMENT;
                  end
                  "*", ">", "<", "=", "!": begin
                     begin_t(); take_c(1'b0); pend_in = c; mode_in = sts_pkg::MODE_OP;
                  end
                  "\"": begin
                     begin_t(); take_c(1'b0); mode_in = sts_pkg::MODE_STRING;
                  end
                  default: begin
                     begin_t(); take_c(1'b0);
                     if (sts_pkg::is_digit(c)) mode_in = sts_pkg::MODE_INT;
                     else if (sts_pkg::is_alpha(c) || c == "_") begin
                        wlen_in = '0; wbuf_in = '0; word_put(c);
                        mode_in = sts_pkg::MODE_IDENT;
                     end else begin
                        unique case (c)
                           "+": k = sts_pkg::KIND_PLUS;
                           "-": k = sts_pkg::KIND_MINUS;
                           "/": k = sts_pkg::KIND_SLASH;
                           ".": k = sts_pkg::KIND_DOT;
                           ",": k = sts_pkg::KIND_COMMA;
                           ";": k = sts_pkg::KIND_SEMI;
                           "(": k = sts_pkg::KIND_LPAREN;
                           ")": k = sts_pkg::KIND_RPAREN;
                           "{": k = sts_pkg::KIND_LBRACE;
                           "}": k = sts_pkg::KIND_RBRACE;
                           default: k = sts_pkg::KIND_UNKNOWN;
                        endcase
                        emit_k(k);
                     end
                  end
               endcase
            end
         end
      end
   end

   function automatic logic [5:0] op_single(input logic [7:0] p);
      unique case (p)
         "*": return sts_pkg::KIND_STAR;
         ">": return sts_pkg::KIND_GT;
         "<": return sts_pkg::KIND_LT;
         "=": return sts_pkg::KIND_ASSIGN;
         default: return sts_pkg::KIND_UNKNOWN;
      endcase
   endfunction

   function automatic logic [5:0] op_double(input logic [7:0] p);
      unique case (p)
         "*": return sts_pkg::KIND_POW;
         ">": return sts_pkg::KIND_GE;
         "<": return sts_pkg::KIND_LE;
         "=": return sts_pkg::KIND_EQ;
         default: return sts_pkg::KIND_NE;
      endcase
   endfunction

   // These void functions act on the next-state variables of the block above.
   function automatic void begin_t();
      soff_in = coff_in; sln_in = cln_in; scol_in = ccol_in; len_in = '0;
   endfunction

   function automatic void take_c(input logic newline);
      len_in  = (len_in  == OFF_MAX) ? OFF_MAX : len_in + 1'b1;
      coff_in = (coff_in == OFF_MAX) ? OFF_MAX : coff_in + 1'b1;
      if (newline && char_byte == "\n") begin
         cln_in  = (cln_in == LN_MAX) ? LN_MAX : cln_in + 1'b1;
         ccol_in = OFFSET_WIDTH'(1);
      end else begin
         ccol_in = (ccol_in == OFF_MAX) ? OFF_MAX : ccol_in + 1'b1;
      end
   endfunction

   function automatic void word_put(input logic [7:0] ch);
      if (wlen_in < WL_W'(KEYWORD_MAX_LEN)) begin
         wbuf_in[8*wlen_in +: 8] = ch;
         wlen_in = wlen_in + 1'b1;
      end else begin
         wlen_in = WL_OVER;
      end
   endfunction

   function automatic void emit_k(input logic [5:0] kd);
      if (tok_count < 3'd3) begin
         tok_kind[6*tok_count[1:0] +: 6] = kd;
         tok_offset[OFFSET_WIDTH*tok_count[1:0] +: OFFSET_WIDTH] = soff_in;
         tok_length[OFFSET_WIDTH*tok_count[1:0] +: OFFSET_WIDTH] = len_in;
         tok_line[LINE_WIDTH*tok_count[1:0] +: LINE_WIDTH] = sln_in;
         tok_column[OFFSET_WIDTH*tok_count[1:0] +: OFFSET_WIDTH] = scol_in;
         tok_count = tok_count + 3'd1;
      end
   endfunction

   function automatic void clear_s();
      mode_in = sts_pkg::MODE_IDLE; pend_in = '0;
      soff_in = '0; len_in = '0; sln_in = LINE_WIDTH'(1); scol_in = OFFSET_WIDTH'(1);
      coff_in = '0; cln_in = LINE_WIDTH'(1); ccol_in = OFFSET_WIDTH'(1);
      wbuf_in = '0; wlen_in = '0;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sts_pkg::MODE_IDLE; pend_ff <= '0;
         soff_ff <= '0; len_ff <= '0; sln_ff <= LINE_WIDTH'(1); scol_ff <= OFFSET_WIDTH'(1);
         coff_ff <= '0; cln_ff <= LINE_WIDTH'(1); ccol_ff <= OFFSET_WIDTH'(1);
         wbuf_ff <= '0; wlen_ff <= '0;
      end else begin
         mode_ff <= mode_in; pend_ff <= pend_in;
         soff_ff <= soff_in; len_ff <= len_in; sln_ff <= sln_in; scol_ff <= scol_in;
         coff_ff <= coff_in; cln_ff <= cln_in; ccol_ff <= ccol_in;
         wbuf_ff <= wbuf_in; wlen_ff <= wlen_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_line_min: assert property (@(posedge clock) disable iff (reset)
      cln_ff != '0) else $error("cursor line dropped to zero");
   a_col_min: assert property (@(posedge clock) disable iff (reset)
      ccol_ff != '0) else $error("cursor column dropped to zero");
   a_eos_idle: assert property (@(posedge clock) disable iff (reset)
      in_valid && end_of_source |=> mode_ff == sts_pkg::MODE_IDLE && coff_ff == '0)
      else $error("end of source did not restart the scanner");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/sts_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sts_back
// Token queue: takes up to three tokens per byte and hands them out one a time.
// ----------------------------------------------------------------------------
module sts_back #(
   parameter int OFFSET_WIDTH = 24,
   parameter int LINE_WIDTH   = 20
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire  [2:0]                 tok_count,
   input  wire  [3*6-1:0]             tok_kind,
   input  wire  [3*OFFSET_WIDTH-1:0]  tok_offset,
   input  wire  [3*OFFSET_WIDTH-1:0]  tok_length,
   input  wire  [3*LINE_WIDTH-1:0]    tok_line,
   input  wire  [3*OFFSET_WIDTH-1:0]  tok_column,
   output logic                       full,
   input  wire                        pop,
   output logic                       empty,
   output logic [5:0]                 token_kind,
   output logic [OFFSET_WIDTH-1:0]    token_offset,
   output logic [OFFSET_WIDTH-1:0]    token_length,
   output logic [LINE_WIDTH-1:0]      token_line,
   output logic [OFFSET_WIDTH-1:0]    token_column,
   output logic                       last_of_run
);

   localparam int DEPTH = 8;
   localparam int W = 7 + 3*OFFSET_WIDTH + LINE_WIDTH;

   logic [W-1:0] q_ff [DEPTH];
   logic [2:0] wp_ff, rp_ff;
   logic [3:0] cnt_ff;
   logic do_pop;
   logic [W-1:0] ent [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ent[i] = {tok_kind[6*i +: 6], tok_offset[OFFSET_WIDTH*i +: OFFSET_WIDTH],
                   tok_length[OFFSET_WIDTH*i +: OFFSET_WIDTH],
                   tok_line[LINE_WIDTH*i +: LINE_WIDTH],
                   tok_column[OFFSET_WIDTH*i +: OFFSET_WIDTH],
                   (tok_count == 3'(i + 1))};
      end
   end

   assign full  = cnt_ff > 4'(DEPTH - 3);
   assign empty = cnt_ff == '0;
   assign do_pop = pop && !empty;
   assign {token_kind, token_offset, token_length, token_line, token_column,
           last_of_run} = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (3'(i) < tok_count) q_ff[wp_ff + 3'(i)] <= ent[i];
      end
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_ff + tok_count;
         rp_ff <= rp_ff + 3'(do_pop);
         cnt_ff <= cnt_ff + 4'(tok_count) - 4'(do_pop);
      end
   end

`ifndef NO_ASSERTIONS
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'(DEPTH)) else $error("token queue overflow");
   a_full_in: assert property (@(posedge clock) disable iff (reset)
      full |-> tok_count == '0) else $error("tokens written while full");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 4'(3'(wp_ff - rp_ff)) || cnt_ff == 4'(DEPTH))
      else $error("queue pointers and count disagree");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/script_token_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// script_token_scanner
// Byte-serial tokenizer with a token queue on the result side.
// ----------------------------------------------------------------------------
// Tokens enter the queue register as their byte is taken; the head feeds rsp_*.
// Throughput: one byte per cycle while not full; a byte may yield up to three
// tokens, popped one per cycle from the eight-entry queue (full when over five).
// Reset: synchronous; scanner returns to line 1, column 1, offset 0, queue empty.
module script_token_scanner #(
   parameter int OFFSET_WIDTH    = 24,
   parameter int LINE_WIDTH      = 20,
   parameter int KEYWORD_MAX_LEN = 8
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   output logic                    full,
   input  wire  [7:0]              req_char_byte,
   input  wire                     req_end_of_source,
   output logic                    empty,
   input  wire                     pop,
   output logic [5:0]              rsp_token_kind,
   output logic [OFFSET_WIDTH-1:0] rsp_token_offset,
   output logic [OFFSET_WIDTH-1:0] rsp_token_length,
   output logic [LINE_WIDTH-1:0]   rsp_token_line,
   output logic [OFFSET_WIDTH-1:0] rsp_token_column,
   output logic                    rsp_last_of_run
);

   logic [2:0] cnt;
   logic [3*6-1:0] kd;
   logic [3*OFFSET_WIDTH-1:0] off, len, col;
   logic [3*LINE_WIDTH-1:0] ln;

   sts_front #(.OFFSET_WIDTH(OFFSET_WIDTH), .LINE_WIDTH(LINE_WIDTH),
      .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_front (
      .clock(clock), .reset(reset), .in_valid(push && !full),
      .char_byte(req_char_byte), .end_of_source(req_end_of_source),
      .tok_count(cnt), .tok_kind(kd), .tok_offset(off), .tok_length(len),
      .tok_line(ln), .tok_column(col));

   sts_back #(.OFFSET_WIDTH(OFFSET_WIDTH), .LINE_WIDTH(LINE_WIDTH)) u_back (
      .clock(clock), .reset(reset), .tok_count(cnt), .tok_kind(kd),
      .tok_offset(off), .tok_length(len), .tok_line(ln), .tok_column(col),
      .full(full), .pop(pop), .empty(empty), .token_kind(rsp_token_kind),
      .token_offset(rsp_token_offset), .token_length(rsp_token_length),
      .token_line(rsp_token_line), .token_column(rsp_token_column),
      .last_of_run(rsp_last_of_run));

endmodule
`default_nettype wire

FILE: tb/script_token_scanner_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// script_token_scanner_checker
// Watches the byte and token channels of the scanner, predicts the tokens
// each accepted byte produces, and compares every popped token field by field.
// ----------------------------------------------------------------------------
module script_token_scanner_checker
   import sts_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   input  wire         full,
   input  wire  [7:0]  req_char_byte,
   input  wire         req_end_of_source,
   input  wire         empty,
   input  wire         pop,
   input  wire  [5:0]  rsp_token_kind,
   input  wire  [23:0] rsp_token_offset,
   input  wire  [23:0] rsp_token_length,
   input  wire  [19:0] rsp_token_line,
   input  wire  [23:0] rsp_token_column,
   input  wire         rsp_last_of_run,
   output int          error_count,
   output int          pending_count,
   output int          token_count
);

   localparam logic [23:0] OFS_MAX  = '1;
   localparam logic [19:0] LINE_MAX = '1;

   typedef struct packed {
      logic [5:0]  kind;
      logic [23:0] offset;
      logic [23:0] length;
      logic [19:0] line;
      logic [23:0] column;
      logic        last;
   } token_type;

   token_type   token_queue[$];
   token_type   run_tokens[$];

   mode_type    mode;
   logic [7:0]  op_byte;
   logic [23:0] tok_offset, tok_length, tok_column;
   logic [19:0] tok_line;
   logic [23:0] cur_offset, cur_column;
   logic [19:0] cur_line;
   logic [7:0]  word_text[KW_MAX];
   logic [3:0]  word_len;

   function automatic logic [23:0] bump24(input logic [23:0] v);
      return (v == OFS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "-" || c == "_";
   endfunction

   task automatic clear_scan();
      mode = MODE_IDLE;
      op_byte = 0;
      tok_offset = 0; tok_length = 0; tok_line = 1; tok_column = 1;
      cur_offset = 0; cur_line = 1; cur_column = 1;
      for (int i = 0; i < KW_MAX; i++) word_text[i] = 0;
      word_len = 0;
   endtask

   function automatic void mark_start();
      tok_offset = cur_offset;
      tok_line = cur_line;
      tok_column = cur_column;
      tok_length = 0;
   endfunction

   function automatic void advance(input logic [7:0] c, input logic lines);
      tok_length = bump24(tok_length);
      cur_offset = bump24(cur_offset);
      if (lines && c == "\n") begin
         cur_line = (cur_line == LINE_MAX) ? cur_line : cur_line + 1'b1;
         cur_column = 1;
      end else begin
         cur_column = bump24(cur_column);
      end
   endfunction

   function automatic void add_token(input logic [5:0] kind);
      token_type t;
      t = '{kind, tok_offset, tok_length, tok_line, tok_column, 1'b0};
      if (run_tokens.size() < 3) run_tokens.push_back(t);
   endfunction

   function automatic void add_word(input logic [7:0] c);
      if (word_len < KW_MAX) begin
         word_text[word_len] = c;
         word_len++;
      end else begin
         word_len = 4'(KW_MAX + 1);
      end
   endfunction

   function automatic logic [5:0] word_kind();
      string names[KW_COUNT];
      logic  hit;
      names = '{"let", "defun", "if", "else", "while", "continue", "break", "return",
                "print", "or", "and", "not", "true", "false", "nil"};
      if (word_len > KW_MAX) return KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (names[k].len() == word_len) begin
            hit = 1;
            for (int i = 0; i < names[k].len(); i++)
               if (names[k][i] != word_text[i]) hit = 0;
            if (hit) return KIND_KW0 + 6'(k);
         end
      end
      return KIND_IDENT;
   endfunction

   function automatic logic [5:0] single_op(input logic [7:0] p);
      case (p)
         "*": return KIND_STAR;
         ">": return KIND_GT;
         "<": return KIND_LT;
         "=": return KIND_ASSIGN;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

   function automatic logic [5:0] double_op(input logic [7:0] p);
      case (p)
         "*": return KIND_POW;
         ">": return KIND_GE;
         "<": return KIND_LE;
         "=": return KIND_EQ;
         default: return KIND_NE;
      endcase
   endfunction

   function automatic void split_dot();
      add_token(KIND_NUMBER);
      mark_start();
      advance(".", 0);
      add_token(KIND_DOT);
   endfunction

   task automatic scan_idle(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         8'h00: begin
            mark_start(); advance(c, 0); add_token(KIND_EOF); clear_scan(); return;
         end
         " ", "\t", "\r", "\n": begin
            advance(c, 1); return;
         end
         "#": begin
            advance(c, 0); mode = MODE_COMMENT; return;
         end
         "*", ">", "<", "=", "!": begin
            mark_start(); advance(c, 0); op_byte = c; mode = MODE_OP; return;
         end
         "\"": begin
            mark_start(); advance(c, 0); mode = MODE_STRING; return;
         end
         "+": k = KIND_PLUS;
         "-": k = KIND_MINUS;
         "/": k = KIND_SLASH;
         ".": k = KIND_DOT;
         ",": k = KIND_COMMA;
         ";": k = KIND_SEMI;
         "(": k = KIND_LPAREN;
         ")": k = KIND_RPAREN;
         "{": k = KIND_LBRACE;
         "}": k = KIND_RBRACE;
         default: begin
            mark_start(); advance(c, 0);
            if (is_digit(c)) begin
               mode = MODE_INT;
            end else if (is_alpha(c) || c == "_") begin
               word_len = 0; add_word(c); mode = MODE_IDENT;
            end else begin
               add_token(KIND_UNKNOWN);
            end
            return;
         end
      endcase
      mark_start(); advance(c, 0); add_token(k);
   endtask

   // returns 1 when the byte must be rescanned from idle
   function automatic logic scan_mode_byte(input logic [7:0] c);
      logic [7:0] second;
      case (mode)
         MODE_COMMENT: begin
            advance(c, 1);
            if (c == "\n") mode = MODE_IDLE;
            return 0;
         end
         MODE_OP: begin
            second = (op_byte == "*") ? "*" : "=";
            mode = MODE_IDLE;
            if (c == second) begin
               advance(c, 0); add_token(double_op(op_byte)); return 0;
            end
            add_token(single_op(op_byte));
            return 1;
         end
         MODE_STRING: begin
            advance(c, 0);
            if (c == "\"") begin
               add_token(KIND_STRING); mode = MODE_IDLE;
            end
            return 0;
         end
         MODE_INT: begin
            if (is_digit(c)) begin advance(c, 0); return 0; end
            if (c == ".") begin mode = MODE_DOT; return 0; end
            if (c == "e" || c == "E") begin
               advance(c, 0); mode = MODE_EXP; return 0;
            end
         end
         MODE_DOT: begin
            if (is_digit(c)) begin
               advance(".", 0); advance(c, 0); mode = MODE_FRAC; return 0;
            end
            split_dot();
            mode = MODE_IDLE;
            return 1;
         end
         MODE_FRAC: begin
            if (is_digit(c)) begin advance(c, 0); return 0; end
            if (c == "e" || c == "E") begin
               advance(c, 0); mode = MODE_EXP; return 0;
            end
         end
         MODE_EXP: begin
            if (is_digit(c) || c == "+" || c == "-") begin
               advance(c, 0); mode = MODE_EXPD; return 0;
            end
         end
         MODE_EXPD: begin
            if (is_digit(c)) begin advance(c, 0); return 0; end
         end
         MODE_IDENT: begin
            if (is_word_char(c)) begin advance(c, 0); add_word(c); return 0; end
            add_token(word_kind());
            mode = MODE_IDLE;
            return 1;
         end
         default: begin
            mode = MODE_IDLE;
            return 1;
         end
      endcase
      add_token(KIND_NUMBER);
      mode = MODE_IDLE;
      return 1;
   endfunction

   task automatic predict_tokens(input logic [7:0] c, input logic eos);
      run_tokens.delete();
      if (eos) begin
         case (mode)
            MODE_OP: add_token(single_op(op_byte));
            MODE_STRING: add_token(KIND_UNKNOWN);
            MODE_INT, MODE_FRAC, MODE_EXP, MODE_EXPD: add_token(KIND_NUMBER);
            MODE_DOT: split_dot();
            MODE_IDENT: add_token(word_kind());
            default: ;
         endcase
         mode = MODE_IDLE;
         mark_start();
         add_token(KIND_EOF);
         clear_scan();
      end else if (mode == MODE_IDLE || scan_mode_byte(c)) begin
         scan_idle(c);
      end
      if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last = 1;
      foreach (run_tokens[i]) token_queue.push_back(run_tokens[i]);
   endtask

   initial begin
      error_count = 0;
      token_count = 0;
      clear_scan();
   end

   assign pending_count = token_queue.size();

   always @(posedge clock) begin
      token_type e;
      if (reset) begin
         token_queue.delete();
         clear_scan();
      end else begin
         if (pop && !empty) begin
            token_count++;
            if (token_queue.size() == 0) begin
               $error("token popped with none expected: kind %0d", rsp_token_kind);
               error_count++;
            end else begin
               e = token_queue.pop_front();
               if (rsp_token_kind !== e.kind) begin
                  $error("token_kind expected %0d actual %0d", e.kind, rsp_token_kind);
                  error_count++;
               end
               if (rsp_token_offset !== e.offset) begin
                  $error("token_offset expected %0d actual %0d", e.offset, rsp_token_offset);
                  error_count++;
               end
               if (rsp_token_length !== e.length) begin
                  $error("token_length expected %0d actual %0d", e.length, rsp_token_length);
                  error_count++;
               end
               if (rsp_token_line !== e.line) begin
                  $error("token_line expected %0d actual %0d", e.line, rsp_token_line);
                  error_count++;
               end
               if (rsp_token_column !== e.column) begin
                  $error("token_column expected %0d actual %0d", e.column, rsp_token_column);
                  error_count++;
               end
               if (rsp_last_of_run !== e.last) begin
                  $error("last_of_run expected %0d actual %0d", e.last, rsp_last_of_run);
                  error_count++;
               end
            end
         end
         if (push && !full) predict_tokens(req_char_byte, req_end_of_source);
      end
   end

endmodule

FILE: tb/script_token_scanner_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// script_token_scanner_test
// Feeds the scanner directed fragments and random source text built from
// token-shaped pieces plus noise bytes, with bursty input and a stalling
// consumer; the checker predicts and compares every token.
// ----------------------------------------------------------------------------
module script_token_scanner_test;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_char_byte;
   logic        req_end_of_source;
   logic        empty;
   logic        pop;
   logic [5:0]  rsp_token_kind;
   logic [23:0] rsp_token_offset;
   logic [23:0] rsp_token_length;
   logic [19:0] rsp_token_line;
   logic [23:0] rsp_token_column;
   logic        rsp_last_of_run;
   int          error_count;
   int          pending_count;
   int          token_count;
   int          byte_count;
   int          hold_cycles;
   logic        pressure_done;
   logic [8:0]  source_bytes[$];

   script_token_scanner dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_char_byte(req_char_byte), .req_end_of_source(req_end_of_source),
      .empty(empty), .pop(pop),
      .rsp_token_kind(rsp_token_kind), .rsp_token_offset(rsp_token_offset),
      .rsp_token_length(rsp_token_length), .rsp_token_line(rsp_token_line),
      .rsp_token_column(rsp_token_column), .rsp_last_of_run(rsp_last_of_run)
   );

   script_token_scanner_checker checker_inst (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_char_byte(req_char_byte), .req_end_of_source(req_end_of_source),
      .empty(empty), .pop(pop),
      .rsp_token_kind(rsp_token_kind), .rsp_token_offset(rsp_token_offset),
      .rsp_token_length(rsp_token_length), .rsp_token_line(rsp_token_line),
      .rsp_token_column(rsp_token_column), .rsp_last_of_run(rsp_last_of_run),
      .error_count(error_count), .pending_count(pending_count),
      .token_count(token_count)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) source_bytes.push_back({1'b0, s[i]});
   endtask

   task automatic add_piece();
      string pieces[24];
      string s;
      int    n;
      pieces = '{"let", "defun", "if", "else", "while", "continue", "break", "return",
                 "print", "or", "and", "not", "true", "false", "nil", "x_1-y",
                 "continues", "**", ">=", "<=", "==", "!=", "12.5e-3", "\"s t\""};
      case ($urandom_range(0, 9))
         0, 1, 2: s = pieces[$urandom_range(0, 23)];
         3: begin
            n = $urandom_range(1, 6);
            s = "";
            for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range("0", "9")))};
            if ($urandom_range(0, 1)) s = {s, "."};
            if ($urandom_range(0, 1)) s = {s, "7"};
            if ($urandom_range(0, 2) == 0) s = {s, "E+"};
         end
         4: s = "+-/.,;(){}*><=!";
         5: s = "# note \n";
         6: s = "\n";
         7: begin
            source_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
            return;
         end
         8: begin
            source_bytes.push_back({1'b1, 8'($urandom_range(0, 255))});
            return;
         end
         default: s = " \t\r";
      endcase
      add_text(s);
      if ($urandom_range(0, 2) != 0) add_text(" ");
   endtask

   initial begin
      int burst;
      reset = 1;
      push = 0;
      req_char_byte = 0;
      req_end_of_source = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      add_text("let x1 = 3.25e+4 ** y;\n# c");
      source_bytes.push_back(9'h000);
      add_text("\n");
      source_bytes.push_back(9'h100);
      add_text("\"ab");
      source_bytes.push_back(9'h000);
      add_text("\"!a 7. 8.e nil_x");
      source_bytes.push_back(9'h000);
      source_bytes.push_back({1'b0, 8'hFF});
      source_bytes.push_back({1'b0, 8'h0B});
      add_text("abcdefghij \"open");
      source_bytes.push_back(9'h100);
      add_text("9e");
      source_bytes.push_back(9'h100);
      add_text("5.");
      source_bytes.push_back(9'h1AA);
      while (source_bytes.size() < 320) add_piece();
      source_bytes.push_back(9'h100);
      byte_count = source_bytes.size();
      while (source_bytes.size() > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && source_bytes.size() > 0) begin
            push <= 1;
            {req_end_of_source, req_char_byte} <= source_bytes[0];
            @(posedge clock);
            if (!full) begin
               void'(source_bytes.pop_front());
               burst--;
            end
         end
         push <= 0;
         repeat ($urandom_range(0, 6)) @(posedge clock);
      end
      push <= 0;
      while (pending_count > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Fed %0d source bytes with end markers and zero bytes; checked %0d tokens.",
               byte_count, token_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         pop <= 0;
         hold_cycles <= 0;
         pressure_done <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         pop <= 0;
      end else if (!pressure_done && token_count > 40) begin
         hold_cycles <= 60;
         pressure_done <= 1;
         pop <= 0;
      end else begin
         pop <= ($urandom_range(0, 3) != 0) || (token_count % 64 > 48);
      end
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/sts_pkg.sv
rtl/core/sts_front.sv
rtl/core/sts_back.sv
rtl/core/script_token_scanner.sv
tb/script_token_scanner_checker.sv
tb/script_token_scanner_test.sv
